[design/mosa_pkg.sv]
// Package for the two-sequence median block: item structs, op codes,
// controller/datapath command and status structs. No dependencies.
package mosa_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int OUT_WIDTH     = DATA_WIDTH + 1;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE       = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] median_doubled;
    logic                        empty_flag;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic setup;
    logic set_empty;
    logic probe;
    logic set_zero;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic both_empty;
    logic range_open;
    logic found;
  } status_t;

endpackage

[design/median_of_two_sorted_arrays.sv]
// Top level of the two-sequence median block: joins controller and datapath.
// Uses mosa_pkg, mosa_ctrl and mosa_datapath (which holds two mosa_ram).
//
// Usage:
//   in_*  channel (valid/ready) carries in_data: op and element_value.
//     op 0 appends element_value to the first sequence, op 1 to the second;
//     a sequence that already holds DEPTH elements drops further appends.
//     op 2 computes twice the combined median and clears both counts.
//     op 3 is dropped.
//   out_* channel (valid/ready) carries one item per op 2: median_doubled
//     and empty_flag (set, with a zero value, when both sequences are empty).
//   Appends are taken one per cycle while idle. A compute item runs the
//   partition search, each probe going through index, registered RAM read
//   and compare, for at most log2(DEPTH)+1 probes, then a finish step; input
//   ready stays low meanwhile. The RAM read latency sets the per-probe cost.
//   The result sits in an output register: appends are accepted while it
//   waits; a further compute holds in its last step until out_ready.
//   Reset (rst_n low, synchronous) clears counts and handshake state; RAM
//   contents are not cleared, and entries beyond the counts are never used.
module median_of_two_sorted_arrays #(
  parameter int DEPTH = mosa_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mosa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mosa_pkg::out_item_t out_data
);

  mosa_pkg::cmd_t    cmd;
  mosa_pkg::status_t status;

  mosa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mosa_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[design/mosa_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mosa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/mosa_datapath.sv]
// Datapath of the two-sequence median block: element RAMs, counts, search
// bounds, probe compare and result register. Uses mosa_pkg and mosa_ram.
module mosa_datapath #(
  parameter int DEPTH = mosa_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mosa_pkg::in_item_t  in_data,
  input  mosa_pkg::cmd_t      cmd,
  output mosa_pkg::status_t   status,
  output mosa_pkg::out_item_t out_data
);

  localparam int DW = mosa_pkg::DATA_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0] fcnt_r, fcnt_nxt, scnt_r, scnt_nxt;
  logic [CW-1:0] m_r, n_r, half_r, i_r, j_r;
  logic [CW:0]   lo_r, hip1_r;
  logic          swap_r, even_r, empty_r;
  logic signed [DW-1:0] a_r, b_r;
  mosa_pkg::out_item_t  out_r;

  logic f_we, s_we;
  logic [AW-1:0] f_raddr_a, f_raddr_b, s_raddr_a, s_raddr_b;
  logic [DW-1:0] f_rdata_a, f_rdata_b, s_rdata_a, s_rdata_b;
  logic [CW-1:0] im1, jm1;

  logic          setup_swap;
  logic [CW-1:0] setup_m, setup_n;
  logic [CW:0]   sum_mn, span;
  logic [CW-1:0] i_nxt;

  logic signed [DW-1:0] sa_i, sa_im1, sb_j, sb_jm1, a_sel, b_sel;
  logic i0, im, j0, jn, left_ok, right_ok, go_right;
  logic signed [DW:0] a_ext, b_ext, sum_out;

  // append path
  assign f_we = cmd.take && (in_data.op == mosa_pkg::OP_APPEND_FIRST) && (fcnt_r < DEPTH_C);
  assign s_we = cmd.take && (in_data.op == mosa_pkg::OP_APPEND_SECOND) && (scnt_r < DEPTH_C);

  always_comb begin
    fcnt_nxt = fcnt_r;
    scnt_nxt = scnt_r;
    if (f_we) begin
      fcnt_nxt = fcnt_r + 1'b1;
    end
    if (s_we) begin
      scnt_nxt = scnt_r + 1'b1;
    end
    if (cmd.setup || cmd.set_empty) begin
      fcnt_nxt = '0;
      scnt_nxt = '0;
    end
  end

  // read addresses: port A at i or j, port B one below
  assign im1 = i_r - 1'b1;
  assign jm1 = j_r - 1'b1;
  assign f_raddr_a = swap_r ? j_r[AW-1:0] : i_r[AW-1:0];
  assign f_raddr_b = swap_r ? jm1[AW-1:0] : im1[AW-1:0];
  assign s_raddr_a = swap_r ? i_r[AW-1:0] : j_r[AW-1:0];
  assign s_raddr_b = swap_r ? im1[AW-1:0] : jm1[AW-1:0];

  mosa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_first_ram (
    .clk     (clk),
    .we      (f_we),
    .waddr   (fcnt_r[AW-1:0]),
    .wdata   (in_data.element_value),
    .raddr_a (f_raddr_a),
    .raddr_b (f_raddr_b),
    .rdata_a (f_rdata_a),
    .rdata_b (f_rdata_b)
  );

  mosa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_second_ram (
    .clk     (clk),
    .we      (s_we),
    .waddr   (scnt_r[AW-1:0]),
    .wdata   (in_data.element_value),
    .raddr_a (s_raddr_a),
    .raddr_b (s_raddr_b),
    .rdata_a (s_rdata_a),
    .rdata_b (s_rdata_b)
  );

  // search setup and probe index
  assign setup_swap = scnt_r < fcnt_r;
  assign setup_m    = setup_swap ? scnt_r : fcnt_r;
  assign setup_n    = setup_swap ? fcnt_r : scnt_r;
  assign sum_mn     = {1'b0, fcnt_r} + {1'b0, scnt_r} + 1'b1;
  assign span       = hip1_r - 1'b1 - lo_r;
  assign i_nxt      = CW'(lo_r + (span >> 1));

  // probe evaluation
  assign sa_i   = swap_r ? s_rdata_a : f_rdata_a;
  assign sa_im1 = swap_r ? s_rdata_b : f_rdata_b;
  assign sb_j   = swap_r ? f_rdata_a : s_rdata_a;
  assign sb_jm1 = swap_r ? f_rdata_b : s_rdata_b;

  assign i0 = (i_r == '0);
  assign im = (i_r == m_r);
  assign j0 = (j_r == '0);
  assign jn = (j_r == n_r);

  assign left_ok  = j0 || im || (sb_jm1 <= sa_i);
  assign right_ok = i0 || jn || (sa_im1 <= sb_j);
  assign go_right = right_ok && (j0 || im || (sb_jm1 >= sa_i));

  always_comb begin
    a_sel = '0;
    b_sel = '0;
    if (!i0) begin
      a_sel = sa_im1;
    end
    if (!j0 && (i0 || (sb_jm1 > sa_im1))) begin
      a_sel = sb_jm1;
    end
    if (!im) begin
      b_sel = sa_i;
    end
    if (!jn && (im || (sb_j < sa_i))) begin
      b_sel = sb_j;
    end
  end

  assign a_ext   = {a_r[DW-1], a_r};
  assign b_ext   = {b_r[DW-1], b_r};
  assign sum_out = even_r ? (a_ext + b_ext) : (a_ext + a_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
      scnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
      scnt_r <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      swap_r <= setup_swap;
      m_r    <= setup_m;
      n_r    <= setup_n;
      half_r <= CW'(sum_mn >> 1);
      even_r <= ~(fcnt_r[0] ^ scnt_r[0]);
      lo_r   <= '0;
      hip1_r <= {1'b0, setup_m} + 1'b1;
    end
    if (cmd.probe) begin
      i_r <= i_nxt;
      j_r <= half_r - i_nxt;
    end
    if (cmd.eval) begin
      if (left_ok && right_ok) begin
        a_r     <= a_sel;
        b_r     <= b_sel;
        empty_r <= 1'b0;
      end else if (go_right) begin
        lo_r <= {1'b0, i_r} + 1'b1;
      end else begin
        hip1_r <= {1'b0, i_r};
      end
    end
    if (cmd.set_empty || cmd.set_zero) begin
      a_r     <= '0;
      b_r     <= '0;
      empty_r <= cmd.set_empty;
      even_r  <= 1'b1;
    end
    if (cmd.load_out) begin
      out_r.median_doubled <= sum_out;
      out_r.empty_flag     <= empty_r;
    end
  end

  assign status.both_empty = (fcnt_r == '0) && (scnt_r == '0);
  assign status.range_open = lo_r < hip1_r;
  assign status.found      = left_ok && right_ok;
  assign out_data          = out_r;

endmodule

[design/mosa_ctrl.sv]
// Controller of the two-sequence median block: search sequencer and
// handshake registers. Uses mosa_pkg.
module mosa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mosa_pkg::status_t status,
  output mosa_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.take      = in_valid && in_ready_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && (in_op == mosa_pkg::OP_COMPUTE)) begin
          if (status.both_empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = ST_FINISH;
          end else begin
            cmd.setup = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status.range_open) begin
          cmd.probe = 1'b1;
          state_nxt = ST_READ;
        end else begin
          cmd.set_zero = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.found ? ST_FINISH : ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == ST_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == ST_IDLE))
    else $error("ready raised outside idle");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while holding an item");

  a_compute_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && (in_op == mosa_pkg::OP_COMPUTE)) |=> (state_r != ST_IDLE) && !in_ready_r)
    else $error("compute item did not start the search");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.setup, cmd.set_empty, cmd.probe, cmd.set_zero, cmd.eval, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded without raising valid");

endmodule
